// ===== hdl/i2p_pkg.sv =====
package i2p_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int CHAR_W          = 8;
    localparam int OP_W            = 3;
    localparam int STATUS_W        = 2;
    localparam int PREC_W          = 3;

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNM_CLOSE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNM_OPEN  = 2'd3;

    localparam logic [OP_W-1:0] OP_LPAREN = 3'd0;
    localparam logic [OP_W-1:0] OP_PLUS   = 3'd1;
    localparam logic [OP_W-1:0] OP_MINUS  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
    localparam logic [OP_W-1:0] OP_POW    = 3'd5;

    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_MUL    = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DIV    = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_POW    = 8'h5E;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic pop;
        logic push;
        logic replace;
        logic clear;
        logic emit;
        logic emit_valid;
        logic emit_top;
        logic last;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_end;
        logic is_lparen;
        logic is_rparen;
        logic is_op;
        logic stk_empty;
        logic top_lparen;
        logic one_left;
        logic second_lparen;
        logic pop_now;
        logic pop_more;
        logic np_zero;
        logic np_one;
        logic out_free;
    } t_dp_stat;

    function automatic logic is_op_char(input logic [CHAR_W-1:0] ch);
        return (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_MUL) ||
               (ch == CH_DIV) || (ch == CH_POW);
    endfunction

    // '(' and non-operators map to OP_LPAREN
    function automatic logic [OP_W-1:0] op_code(input logic [CHAR_W-1:0] ch);
        logic [OP_W-1:0] code;
        unique case (ch)
            CH_PLUS:  code = OP_PLUS;
            CH_MINUS: code = OP_MINUS;
            CH_MUL:   code = OP_MUL;
            CH_DIV:   code = OP_DIV;
            CH_POW:   code = OP_POW;
            default:  code = OP_LPAREN;
        endcase
        return code;
    endfunction

    function automatic logic [PREC_W-1:0] in_prec(input logic [OP_W-1:0] code);
        logic [PREC_W-1:0] p;
        unique case (code)
            OP_PLUS, OP_MINUS: p = 3'd1;
            OP_MUL, OP_DIV:    p = 3'd3;
            OP_POW:            p = 3'd6;
            default:           p = 3'd0;
        endcase
        return p;
    endfunction

    function automatic logic [PREC_W-1:0] stk_prec(input logic [OP_W-1:0] code);
        logic [PREC_W-1:0] p;
        unique case (code)
            OP_PLUS, OP_MINUS: p = 3'd2;
            OP_MUL, OP_DIV:    p = 3'd4;
            OP_POW:            p = 3'd5;
            default:           p = 3'd0;
        endcase
        return p;
    endfunction

    function automatic logic [CHAR_W-1:0] op_char(input logic [OP_W-1:0] code);
        logic [CHAR_W-1:0] c;
        unique case (code)
            OP_LPAREN: c = CH_LPAREN;
            OP_PLUS:   c = CH_PLUS;
            OP_MINUS:  c = CH_MINUS;
            OP_MUL:    c = CH_MUL;
            OP_DIV:    c = CH_DIV;
            OP_POW:    c = CH_POW;
            default:   c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/i2p_ram.sv =====
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write-first on a same-address read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/i2p_datapath.sv =====
module i2p_datapath import i2p_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic                i_req_type,
    input  logic [CHAR_W-1:0]   i_char_in,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [CHAR_W-1:0]   o_out_char,
    output logic                o_char_valid,
    output logic                o_run_last,
    output logic [STATUS_W-1:0] o_status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic                r_req;
    logic [CHAR_W-1:0]   r_char;
    logic [STATUS_W-1:0] r_status;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_lp;
    logic [OP_W-1:0]     r_top;
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_cvalid;
    logic                r_out_last;
    logic [STATUS_W-1:0] r_out_status;

    logic [CW-1:0]       n_count;
    logic [CW-1:0]       n_lp;
    logic [OP_W-1:0]     n_top;
    logic [STATUS_W-1:0] n_status;

    logic [OP_W-1:0]     w_code;
    logic [OP_W-1:0]     w_push_code;
    logic [PREC_W-1:0]   w_ip;
    logic                w_full;
    logic                w_empty;
    logic                w_push_ok;
    logic [CW-1:0]       w_np;
    logic [CW-1:0]       w_rd_full;
    logic [CW-1:0]       w_wr_full;
    logic [OP_W-1:0]     w_second;
    logic [CHAR_W-1:0]   w_emit_char;

    assign w_code      = op_code(r_char);
    assign w_push_code = (r_char == CH_LPAREN) ? OP_LPAREN : w_code;
    assign w_ip        = in_prec(w_code);
    assign w_full      = (r_count == CW'(STACK_DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_np        = r_count - r_lp;
    assign w_push_ok   = i_cmd.push && !w_full;

    always_comb begin
        o_stat.is_end        = (r_req == REQ_END);
        o_stat.is_lparen     = (r_req == REQ_CHAR) && (r_char == CH_LPAREN);
        o_stat.is_rparen     = (r_req == REQ_CHAR) && (r_char == CH_RPAREN);
        o_stat.is_op         = (r_req == REQ_CHAR) && is_op_char(r_char);
        o_stat.stk_empty     = w_empty;
        o_stat.top_lparen    = (r_top == OP_LPAREN);
        o_stat.one_left      = (r_count == CW'(1));
        o_stat.second_lparen = (w_second == OP_LPAREN);
        o_stat.pop_now       = !w_empty && (stk_prec(r_top) > w_ip);
        o_stat.pop_more      = (r_count > CW'(1)) && (stk_prec(w_second) > w_ip);
        o_stat.np_zero       = (w_np == '0);
        o_stat.np_one        = (w_np == CW'(1));
        o_stat.out_free      = !r_out_valid || i_out_ready;
    end

    // run status is known before the first result
    always_comb begin
        n_status = ST_OK;
        if (i_req_type == REQ_END) begin
            if (r_lp != '0) begin
                n_status = ST_UNM_OPEN;
            end
        end else if (i_char_in == CH_LPAREN) begin
            if (w_full) begin
                n_status = ST_OVERFLOW;
            end
        end else if (i_char_in == CH_RPAREN) begin
            if (r_lp == '0) begin
                n_status = ST_UNM_CLOSE;
            end
        end else if (is_op_char(i_char_in)) begin
            if (w_full && !(stk_prec(r_top) > in_prec(op_code(i_char_in)))) begin
                n_status = ST_OVERFLOW;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_lp    = r_lp;
        n_top   = r_top;
        if (i_cmd.clear) begin
            n_count = '0;
            n_lp    = '0;
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
            n_top   = w_second;
            if (r_top == OP_LPAREN) begin
                n_lp = r_lp - CW'(1);
            end
        end else if (w_push_ok) begin
            n_count = r_count + CW'(1);
            n_top   = w_push_code;
            if (w_push_code == OP_LPAREN) begin
                n_lp = r_lp + CW'(1);
            end
        end else if (i_cmd.replace) begin
            n_top = w_push_code;
        end
    end

    // RAM holds every entry below the top; its read port tracks the second entry
    assign w_rd_full = n_count - CW'(2);
    assign w_wr_full = r_count - CW'(1);

    i2p_ram #(
        .WIDTH (OP_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_push_ok && !w_empty),
        .i_waddr (w_wr_full[AW-1:0]),
        .i_wdata (r_top),
        .i_raddr (w_rd_full[AW-1:0]),
        .o_rdata (w_second)
    );

    assign w_emit_char = !i_cmd.emit_valid ? '0 :
                         i_cmd.emit_top    ? op_char(r_top) : r_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_lp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_lp    <= n_lp;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (i_cmd.load_in) begin
            r_req    <= i_req_type;
            r_char   <= i_char_in;
            r_status <= n_status;
        end
        if (i_cmd.emit) begin
            r_out_char   <= w_emit_char;
            r_out_cvalid <= i_cmd.emit_valid;
            r_out_last   <= i_cmd.last;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_char_valid = r_out_cvalid;
    assign o_run_last   = r_out_last;
    assign o_status     = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_lp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lp <= r_count)
        else $error("open paren count above stack count");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && w_full && !i_cmd.clear && !i_cmd.pop) |=> w_full)
        else $error("push onto full stack not dropped");

endmodule

// ===== hdl/i2p_ctrl.sv =====
module i2p_ctrl import i2p_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DROP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    if (i_stat.is_end) begin
                        if (i_stat.np_zero) begin
                            o_cmd.emit  = 1'b1;
                            o_cmd.last  = 1'b1;
                            o_cmd.clear = 1'b1;
                            n_state     = S_IDLE;
                        end else if (i_stat.top_lparen) begin
                            o_cmd.pop = 1'b1;
                        end else begin
                            o_cmd.emit       = 1'b1;
                            o_cmd.emit_valid = 1'b1;
                            o_cmd.emit_top   = 1'b1;
                            if (i_stat.np_one) begin
                                // only open parens remain below
                                o_cmd.last  = 1'b1;
                                o_cmd.clear = 1'b1;
                                n_state     = S_IDLE;
                            end else begin
                                o_cmd.pop = 1'b1;
                            end
                        end
                    end else if (i_stat.is_lparen) begin
                        o_cmd.push = 1'b1;
                        o_cmd.emit = 1'b1;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end else if (i_stat.is_rparen) begin
                        if (i_stat.stk_empty) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            n_state    = S_IDLE;
                        end else if (i_stat.top_lparen) begin
                            o_cmd.pop  = 1'b1;
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            o_cmd.pop        = 1'b1;
                            o_cmd.emit       = 1'b1;
                            o_cmd.emit_valid = 1'b1;
                            o_cmd.emit_top   = 1'b1;
                            if (i_stat.one_left) begin
                                o_cmd.last = 1'b1;
                                n_state    = S_IDLE;
                            end else if (i_stat.second_lparen) begin
                                o_cmd.last = 1'b1;
                                n_state    = S_DROP;
                            end
                        end
                    end else if (i_stat.is_op) begin
                        if (i_stat.pop_now) begin
                            o_cmd.emit       = 1'b1;
                            o_cmd.emit_valid = 1'b1;
                            o_cmd.emit_top   = 1'b1;
                            if (i_stat.pop_more) begin
                                o_cmd.pop = 1'b1;
                            end else begin
                                // final pop and push fold into one top update
                                o_cmd.replace = 1'b1;
                                o_cmd.last    = 1'b1;
                                n_state       = S_IDLE;
                            end
                        end else begin
                            o_cmd.push = 1'b1;
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end else begin
                        o_cmd.emit       = 1'b1;
                        o_cmd.emit_valid = 1'b1;
                        o_cmd.last       = 1'b1;
                        n_state          = S_IDLE;
                    end
                end
            end
            S_DROP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_drop_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DROP) |=> (r_state == S_IDLE))
        else $error("paren drop did not finish in one cycle");

    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> (r_state == S_EXEC))
        else $error("accepted transaction not executed");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result overwrites pending output");

endmodule

// ===== hdl/infix_to_postfix_converter.sv =====
// A request is accepted only in S_IDLE and registered; S_EXEC then emits its results
// one per step while the output is free. Operands, '(' and non-popping operators take
// one step; an operator emits each popped entry, ')' emits each popped operator and
// S_DROP drops a matched '(' under them; end pops down to the deepest operator.
// Reset: synchronous active-low; clears stack count, paren count, FSM and output valid.
// Stack RAM contents are not cleared.
module infix_to_postfix_converter import i2p_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,  // [7:0] char_in
    input  logic [0:0]        s_axis_tuser,  // [0] req_type
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [CHAR_W-1:0] m_axis_tdata,  // [7:0] out_char
    output logic [2:0]        m_axis_tuser,  // [0] char_valid, [2:1] status
    output logic              m_axis_tlast   // run_last
);

    t_dp_cmd             w_cmd;
    t_dp_stat            w_stat;
    logic                w_char_valid;
    logic [STATUS_W-1:0] w_status;

    i2p_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    i2p_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_req_type   (s_axis_tuser[0]),
        .i_char_in    (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_char   (m_axis_tdata),
        .o_char_valid (w_char_valid),
        .o_run_last   (m_axis_tlast),
        .o_status     (w_status)
    );

    assign m_axis_tuser = {w_status, w_char_valid};

endmodule
